FILE: design/set_assoc_index_lru_ranks_top_defines.svh
// Assertion macros for the set-associative LRU rank index.
`ifndef SET_ASSOC_INDEX_LRU_RANKS_TOP_DEFINES_SVH
`define SET_ASSOC_INDEX_LRU_RANKS_TOP_DEFINES_SVH

// Same-cycle implication, checked on clk_i outside reset.
`define SALRU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk_i outside reset.
`define SALRU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/salru_pkg.sv
// Types and constants shared by the set-associative LRU rank index.
`default_nettype none

package salru_pkg;

  localparam int unsigned NUM_WAYS     = 8;
  localparam int unsigned RANK_BITS    = 3;
  localparam int unsigned TAG_BITS     = 8;
  localparam int unsigned WAY_W        = 3;
  localparam int unsigned HASH_W       = 32;
  localparam int unsigned NUM_SETS_DEF = 1024;

  localparam logic [RANK_BITS-1:0] TOP_RANK  = RANK_BITS'(NUM_WAYS - 1);
  localparam logic [WAY_W-1:0]     LAST_WAY  = WAY_W'(NUM_WAYS - 1);
  localparam logic [TAG_BITS-1:0]  TAG_ONES  = '1;

  typedef enum logic [1:0] {
    ACT_READ    = 2'd0,
    ACT_UPDATE  = 2'd1,
    ACT_DISCARD = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'd0,
    ST_IDLE  = 2'd1,
    ST_LOOK  = 2'd2,
    ST_EMIT  = 2'd3
  } state_e;

  typedef struct packed {
    logic [1:0]          action;
    logic [HASH_W-1:0]   hash;
    logic [WAY_W-1:0]    way;
    logic [TAG_BITS-1:0] tag;
  } in_beat_t;

  typedef struct packed {
    logic [WAY_W-1:0]     out_way;
    logic [TAG_BITS-1:0]  out_tag;
    logic [RANK_BITS-1:0] out_rank;
    logic                 status;
    logic                 last;
  } out_beat_t;

  typedef struct packed {
    logic [NUM_WAYS-1:0][TAG_BITS-1:0]  tags;
    logic [NUM_WAYS-1:0][RANK_BITS-1:0] ranks;
  } row_t;

  typedef struct packed {
    row_t row;
    logic ignored;
  } upd_t;

endpackage

`default_nettype wire

FILE: design/salru_row_upd.sv
// Set row modify: update promotes a way to top rank, discard demotes it to rank 0 (ignored if already at rank 0).
`default_nettype none

module salru_row_upd (
  input  salru_pkg::row_t             row_i,
  input  logic                        discard_i,
  input  logic [salru_pkg::WAY_W-1:0] way_i,
  input  logic [salru_pkg::TAG_BITS-1:0] tag_i,
  output salru_pkg::upd_t             upd_o
);
  import salru_pkg::*;

  logic [RANK_BITS-1:0] cut;

  assign cut = row_i.ranks[way_i];

  always_comb begin
    upd_o.row     = row_i;
    upd_o.ignored = 1'b0;
    if (!discard_i) begin
      upd_o.row.tags[way_i] = tag_i;
      if (cut != TOP_RANK) begin
        for (int i = 0; i < NUM_WAYS; i++) begin
          if (row_i.ranks[i] > cut) begin
            upd_o.row.ranks[i] = row_i.ranks[i] - RANK_BITS'(1);
          end else if (row_i.ranks[i] == cut) begin
            upd_o.row.ranks[i] = TOP_RANK;
          end
        end
      end
    end else if (cut == '0) begin
      upd_o.ignored = 1'b1;
    end else begin
      upd_o.row.tags[way_i] = TAG_ONES;
      for (int i = 0; i < NUM_WAYS; i++) begin
        if (row_i.ranks[i] < cut) begin
          upd_o.row.ranks[i] = row_i.ranks[i] + RANK_BITS'(1);
        end else if (row_i.ranks[i] == cut) begin
          upd_o.row.ranks[i] = '0;
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/set_assoc_index_lru_ranks_top.sv
// Set-associative tag index with per-way LRU ranks held in one set-wide memory.
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_beat_i) carries one request per
//   beat: read a set, update a way with a tag, or discard a way. The set is the
//   low log2(NUM_SETS) bits of hash; NUM_SETS must be a power of two.
//   Output channel (out_valid_o / out_stall_i / out_beat_o) returns results.
//   Each set is one memory row (all tags and ranks), read through a register.
//   Update or discard: one read-modify-write of the row in ST_LOOK; the result
//   beat is loaded into the output register once it is free, and no new request
//   is taken until then.
//   Read: one result beat per way, last on way NUM_WAYS-1; after ST_LOOK, ST_EMIT
//   loads the beats in way order; no new request is taken until the last one.
//   Codes outside the action set and out-of-range ways are taken and dropped.
//   Reset: a clearing pass writes every row (tags zero, way j at rank j);
//   in_stall_o stays high until it ends.
//   A stalled output holds its beat; the block waits for the output register to
//   drain before writing the next result.
`default_nettype none
`include "set_assoc_index_lru_ranks_top_defines.svh"

module set_assoc_index_lru_ranks_top #(
  parameter int unsigned NUM_SETS = salru_pkg::NUM_SETS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  salru_pkg::in_beat_t  in_beat_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output salru_pkg::out_beat_t out_beat_o
);
  import salru_pkg::*;

  localparam int unsigned SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam logic [SET_W-1:0] CLR_LAST = SET_W'(NUM_SETS - 1);

  state_e               state_q, state_d;
  logic [SET_W-1:0]     clr_q, clr_d;
  logic [WAY_W-1:0]     way_cnt_q, way_cnt_d;
  logic                 out_valid_q, out_valid_d;
  out_beat_t            out_beat_q, out_beat_d;
  logic                 out_load;
  logic                 out_free;

  action_e              act_q;
  logic [SET_W-1:0]     set_q;
  logic [WAY_W-1:0]     way_q;
  logic [TAG_BITS-1:0]  tag_q;

  row_t                 mem_q [NUM_SETS];
  row_t                 rd_row_q;
  row_t                 rst_row;
  row_t                 mem_wdata;
  logic [SET_W-1:0]     mem_waddr;
  logic                 mem_we;
  logic                 mem_re;

  logic                 in_fire;
  logic                 item_ok;
  upd_t                 upd;

  assign in_fire  = in_valid_i && !in_stall_o;
  assign mem_re   = in_fire;
  assign out_free = !out_valid_q || !out_stall_i;

  assign item_ok = (in_beat_i.action == ACT_READ) ||
                   (((in_beat_i.action == ACT_UPDATE) || (in_beat_i.action == ACT_DISCARD)) &&
                    ({1'b0, in_beat_i.way} < (WAY_W + 1)'(NUM_WAYS)));

  always_comb begin
    for (int j = 0; j < NUM_WAYS; j++) begin
      rst_row.tags[j]  = '0;
      rst_row.ranks[j] = RANK_BITS'(j);
    end
  end

  salru_row_upd u_row_upd (
    .row_i     (rd_row_q),
    .discard_i (act_q == ACT_DISCARD),
    .way_i     (way_q),
    .tag_i     (tag_q),
    .upd_o     (upd)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == CLR_LAST) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_fire && item_ok) state_d = ST_LOOK;
      end
      ST_LOOK: begin
        if (act_q == ACT_READ) begin
          state_d = ST_EMIT;
        end else if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_free && (way_cnt_q == LAST_WAY)) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    in_stall_o = 1'b1;
    mem_we     = 1'b0;
    mem_waddr  = set_q;
    mem_wdata  = upd.row;
    out_load   = 1'b0;
    out_beat_d = out_beat_q;
    clr_d      = clr_q;
    way_cnt_d  = way_cnt_q;
    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = rst_row;
        clr_d     = clr_q + SET_W'(1);
      end
      ST_IDLE: begin
        in_stall_o = 1'b0;
        way_cnt_d  = '0;
      end
      ST_LOOK: begin
        if ((act_q != ACT_READ) && out_free) begin
          mem_we              = 1'b1;
          out_load            = 1'b1;
          out_beat_d.out_way  = way_q;
          out_beat_d.out_tag  = upd.row.tags[way_q];
          out_beat_d.out_rank = upd.row.ranks[way_q];
          out_beat_d.status   = upd.ignored;
          out_beat_d.last     = 1'b1;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_load            = 1'b1;
          out_beat_d.out_way  = way_cnt_q;
          out_beat_d.out_tag  = rd_row_q.tags[way_cnt_q];
          out_beat_d.out_rank = rd_row_q.ranks[way_cnt_q];
          out_beat_d.status   = 1'b0;
          out_beat_d.last     = (way_cnt_q == LAST_WAY);
          way_cnt_d           = way_cnt_q + WAY_W'(1);
        end
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      way_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      way_cnt_q   <= way_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_beat_q <= out_beat_d;
    if (in_fire) begin
      act_q <= action_e'(in_beat_i.action);
      set_q <= in_beat_i.hash[SET_W-1:0];
      way_q <= in_beat_i.way;
      tag_q <= in_beat_i.tag;
    end
  end

  // set memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_row_q <= mem_q[in_beat_i.hash[SET_W-1:0]];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

  `SALRU_ASSERT_NOW(a_no_rw_overlap, mem_we, !mem_re, "memory read and write overlap")
  `SALRU_ASSERT_NEXT(a_emit_ends, (state_q == ST_EMIT) && out_load && out_beat_d.last, state_q == ST_IDLE, "read did not end after last way")
  `SALRU_ASSERT_NEXT(a_accept_goes_look, in_fire && item_ok, state_q == ST_LOOK, "accepted beat did not reach lookup")

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for the set-associative tag index with LRU ranks.
module testbench;
  import salru_pkg::*;

  localparam int unsigned SETS    = 1024;
  localparam int          DRAIN_A = 18;
  localparam int          DRAIN_B = 78;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall_o;
  in_beat_t  in_beat = '0;
  logic      out_valid_o;
  logic      out_stall = 1'b0;
  out_beat_t out_beat_o;

  in_beat_t  request_q[$];
  out_beat_t due_q[$];
  logic [TAG_BITS-1:0]  tag_mem[SETS][NUM_WAYS];
  logic [RANK_BITS-1:0] rank_mem[SETS][NUM_WAYS];

  int   sent_cnt = 0;
  int   total = 0;
  int   err_cnt = 0;
  int   gap_left = 0;
  int   stall_left = 0;
  logic hold = 1'b0;
  logic calm = 1'b0;
  logic drained = 1'b1;

  set_assoc_index_lru_ranks_top #(.NUM_SETS(SETS)) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall_o),
    .in_beat_i  (in_beat),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall),
    .out_beat_o (out_beat_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  task automatic flag_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $time, what);
    err_cnt++;
  endtask

  task automatic add_request(input logic [1:0] act, input logic [HASH_W-1:0] h,
                             input logic [WAY_W-1:0] w, input logic [TAG_BITS-1:0] t);
    in_beat_t req;
    req.action = act;
    req.hash = h;
    req.way = w;
    req.tag = t;
    request_q.push_back(req);
  endtask

  task automatic push_result(input int unsigned s, input int unsigned w,
                             input logic st, input logic lst);
    out_beat_t res;
    res.out_way = WAY_W'(w);
    res.out_tag = tag_mem[s][w];
    res.out_rank = rank_mem[s][w];
    res.status = st;
    res.last = lst;
    due_q.push_back(res);
  endtask

  // Apply one request to the shadow index and queue the beats it yields.
  task automatic apply_request(input in_beat_t req);
    int unsigned s;
    logic [RANK_BITS-1:0] cut;
    s = req.hash % SETS;
    if (req.action == ACT_READ) begin
      for (int w = 0; w < NUM_WAYS; w++) push_result(s, w, 1'b0, w == NUM_WAYS - 1);
    end else if (req.way < NUM_WAYS && req.action == ACT_UPDATE) begin
      tag_mem[s][req.way] = req.tag;
      cut = rank_mem[s][req.way];
      if (cut != TOP_RANK) begin
        for (int i = 0; i < NUM_WAYS; i++) begin
          if (rank_mem[s][i] > cut) rank_mem[s][i] = rank_mem[s][i] - 1'b1;
          else if (rank_mem[s][i] == cut) rank_mem[s][i] = TOP_RANK;
        end
      end
      push_result(s, req.way, 1'b0, 1'b1);
    end else if (req.way < NUM_WAYS && req.action == ACT_DISCARD) begin
      cut = rank_mem[s][req.way];
      if (cut != '0) begin
        tag_mem[s][req.way] = TAG_ONES;
        for (int i = 0; i < NUM_WAYS; i++) begin
          if (rank_mem[s][i] < cut) rank_mem[s][i] = rank_mem[s][i] + 1'b1;
          else if (rank_mem[s][i] == cut) rank_mem[s][i] = '0;
        end
      end
      push_result(s, req.way, cut == '0, 1'b1);
    end
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_beat <= '0;
      gap_left <= 0;
      hold <= 1'b0;
      sent_cnt <= 0;
      calm <= 1'b0;
    end else begin
      calm <= request_q.size() < 20;
      if (in_valid && !in_stall_o) sent_cnt <= sent_cnt + 1;
      if (in_valid && !in_stall_o && (sent_cnt + 1 == DRAIN_A || sent_cnt + 1 == DRAIN_B)) begin
        in_valid <= 1'b0;
        hold <= 1'b1;
      end else if (hold) begin
        if (drained) hold <= 1'b0;
      end else if (!in_valid || !in_stall_o) begin
        if (gap_left != 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
          in_valid <= 1'b0;
          gap_left <= $urandom_range(0, 11);
        end else if (request_q.size() != 0) begin
          in_valid <= 1'b1;
          in_beat <= request_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result sink back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 11);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin : mon
    out_beat_t want;
    if (!rst_ni) begin
      drained <= 1'b1;
    end else begin
      if (out_valid_o && !out_stall) begin
        if (due_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected beat %p", out_beat_o));
        end else begin
          want = due_q.pop_front();
          if (out_beat_o.out_way != want.out_way)
            flag_mismatch($sformatf("out_way %0d, want %0d", out_beat_o.out_way, want.out_way));
          if (out_beat_o.out_tag != want.out_tag)
            flag_mismatch($sformatf("out_tag %h, want %h", out_beat_o.out_tag, want.out_tag));
          if (out_beat_o.out_rank != want.out_rank)
            flag_mismatch($sformatf("out_rank %0d, want %0d", out_beat_o.out_rank,
                                    want.out_rank));
          if (out_beat_o.status != want.status)
            flag_mismatch($sformatf("status %b, want %b", out_beat_o.status, want.status));
          if (out_beat_o.last != want.last)
            flag_mismatch($sformatf("last %b, want %b", out_beat_o.last, want.last));
        end
      end
      if (in_valid && !in_stall_o) apply_request(in_beat);
      drained <= due_q.size() == 0;
    end
  end

  initial begin
    #400000;
    $display("set_assoc_index_lru_ranks_top test failed");
    $finish;
  end

  initial begin : main
    logic [HASH_W-1:0] pool[4];
    logic [HASH_W-1:0] h;
    int pick;
    for (int s = 0; s < SETS; s++) begin
      for (int w = 0; w < NUM_WAYS; w++) begin
        tag_mem[s][w] = '0;
        rank_mem[s][w] = RANK_BITS'(w);
      end
    end

    add_request(ACT_READ, 32'h0, 3'd0, 8'h00);
    add_request(ACT_UPDATE, 32'h0, LAST_WAY, 8'hA5);
    add_request(ACT_UPDATE, 32'h0, 3'd0, 8'hFF);
    add_request(ACT_DISCARD, 32'h0, 3'd1, 8'h3C);
    add_request(ACT_DISCARD, 32'h0, 3'd0, 8'h00);
    add_request(ACT_READ, 32'h0, 3'd4, 8'h77);
    add_request(2'd3, 32'hFFFF_FFFF, 3'd7, 8'hFF);
    add_request(ACT_UPDATE, 32'hFFFF_FFFF, 3'd7, 8'h00);
    add_request(ACT_UPDATE, 32'hFFFF_FFFF, 3'd3, 8'h5A);
    add_request(ACT_DISCARD, 32'hFFFF_FFFF, 3'd0, 8'hFF);
    add_request(ACT_DISCARD, 32'hFFFF_FFFF, 3'd7, 8'h00);
    add_request(ACT_READ, 32'hFFFF_FC00, 3'd7, 8'hFF);
    add_request(ACT_READ, 32'hFFFF_FFFF, 3'd2, 8'h00);
    add_request(ACT_UPDATE, 32'h0000_0155, 3'd5, 8'h01);
    add_request(ACT_DISCARD, 32'h0000_0155, 3'd5, 8'h80);
    add_request(ACT_UPDATE, 32'h8000_0155, 3'd5, 8'h80);
    add_request(ACT_READ, 32'h0000_0155, 3'd0, 8'h00);
    add_request(2'd3, 32'h0, 3'd0, 8'h00);

    // random part: mostly traffic on a few hot sets so ranks get churned
    for (int i = 0; i < 4; i++) pool[i] = $urandom_range(0, SETS - 1);
    for (int i = 0; i < 102; i++) begin
      h = $urandom();
      if ($urandom_range(0, 9) < 8) h[9:0] = pool[$urandom_range(0, 3)][9:0];
      pick = $urandom_range(0, 99);
      if (pick < 20) add_request(ACT_READ, h, WAY_W'($urandom()), TAG_BITS'($urandom()));
      else if (pick < 60)
        add_request(ACT_UPDATE, h, WAY_W'($urandom()), TAG_BITS'($urandom()));
      else if (pick < 95)
        add_request(ACT_DISCARD, h, WAY_W'($urandom()), TAG_BITS'($urandom()));
      else add_request(2'd3, h, WAY_W'($urandom()), TAG_BITS'($urandom()));
    end
    total = request_q.size();

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    @(posedge clk_i);
    while (sent_cnt != total || hold || !drained) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (due_q.size() != 0) flag_mismatch($sformatf("%0d beats never arrived", due_q.size()));
    if (err_cnt == 0) begin
      $display("set_assoc_index_lru_ranks_top test passed");
    end else begin
      $display("set_assoc_index_lru_ranks_top test failed");
    end
    $finish;
  end

endmodule
